// ----- sv/sptp_pkg.sv -----
// shared constants, types and tables for the sonar packet to points block
`timescale 1ns / 1ps
package sptp_pkg;
	localparam int DATA_START_DEF = 256;
	localparam int TRIG_BITS_DEF = 16;
	localparam int POS_W = 18;
	localparam logic [POS_W-1:0] POS_MAX = 18'h3FFFF;
	localparam logic [8:0] START_RST = 9'd210;
	localparam logic [8:0] SPAN_RST = 9'd120;
	localparam logic [0:0] REG_START = 1'b0;
	localparam logic [0:0] REG_SPAN = 1'b1;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] Q30 = 34'sd1073741824;

	typedef struct packed {
		logic [15:0] beam;
		logic        last;
	} beat_ctl_t;

	function automatic logic [31:0] atan_val(input int i);
		logic [31:0] t [24];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
			32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443,
			32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
			32'd652, 32'd326, 32'd163, 32'd81};
		return t[5'(i)];
	endfunction
endpackage

// ----- sv/sptp_cell.sv -----
// one cordic rotation cell of the chain
`timescale 1ns / 1ps
module sptp_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vin,
	input  logic signed [33:0] xin,
	input  logic signed [33:0] yin,
	input  logic signed [33:0] zin,
	output logic               vout,
	output logic signed [33:0] xout,
	output logic signed [33:0] yout,
	output logic signed [33:0] zout
);
	import sptp_pkg::*;
	logic signed [33:0] at;
	assign at = $signed({2'b00, atan_val(STEP)});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else vout <= vin;
	end
	always_ff @(posedge clk) begin
		if (vin) begin
			if (!zin[33]) begin
				xout <= xin - (yin >>> STEP);
				yout <= yin + (xin >>> STEP);
				zout <= zin - at;
			end else begin
				xout <= xin + (yin >>> STEP);
				yout <= yin - (xin >>> STEP);
				zout <= zin + at;
			end
		end
	end
endmodule

// ----- sv/sptp_div.sv -----
// radix-2 divider for the angle increment
`timescale 1ns / 1ps
module sptp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [40:0] num,
	input  logic [24:0] den,
	output logic        busy,
	output logic [31:0] quo
);
	logic [40:0] n_q;
	logic [25:0] r_q;
	logic [24:0] d_q;
	logic [5:0]  cnt_q;
	logic [25:0] sh;
	assign sh = {r_q[24:0], n_q[40]};
	assign busy = cnt_q != 6'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (start) cnt_q <= 6'd41;
		else if (busy) cnt_q <= cnt_q - 6'd1;
	end
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy) begin
			if (d_q == '0) begin
				n_q <= '0;
			end else if (sh >= {1'b0, d_q}) begin
				r_q <= sh - {1'b0, d_q};
				n_q <= {n_q[39:0], 1'b1};
			end else begin
				r_q <= sh;
				n_q <= {n_q[39:0], 1'b0};
			end
		end
	end
	assign quo = n_q[31:0];
endmodule

// ----- sv/sonar_packet_to_points.sv -----
// top level: header capture, cordic cell chain, scaling and output register
// channel | dir | tdata (low bit up)                              | tuser
// s_axis  | in  | packet_byte[7:0]                                | end_of_packet
// m_axis  | out | x_mm[32:0] y_mm[32:0] beam_index[15:0] lat[16:0] | last_point
// (m tdata: x 0..32, y 33..65, beam_index 66..81, latency_total 82..98, zero to 103)
// after its second range byte a point passes the chain input register, the cordic cells,
// the rounding and scaling registers and the output register, which holds it until taken
// bytes are taken one a cycle while s_tready is high; s_tready drops while a point is in flight or waiting
// the increment divider runs after byte 71, and s_tready is low while it is busy
// reset clears all control state and brings fan registers to 210 and 120 degrees
`timescale 1ns / 1ps
module sonar_packet_to_points #(
	parameter int DATA_START = sptp_pkg::DATA_START_DEF,
	parameter int TRIG_BITS = sptp_pkg::TRIG_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [8:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // packet_byte
	input  logic         s_tuser,   // end_of_packet
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // x_mm, y_mm, beam_index, latency_total
	output logic         m_tuser    // last_point
);
	import sptp_pkg::*;
	localparam int NC = (TRIG_BITS < 24) ? TRIG_BITS : 24;
	localparam int SH = 31 - TRIG_BITS;
	localparam logic signed [33:0] LIM = 34'sd1 <<< (TRIG_BITS - 1);

	logic [8:0] start_q, span_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0] btot_q, rstep_q, ping_q, dat_q, done_q;
	logic [7:0] hold_q;
	logic [31:0] ang_q;
	logic busy_s, acc, fire;
	logic [15:0] word;
	logic inflight_q, out_v_q;
	logic dstart;
	logic [31:0] quo;
	logic [40:0] dnum;
	logic [24:0] dden;
	logic [28:0] frac_p;
	logic [31:0] ang_base;
	beat_ctl_t ctl_q;

	assign word = {hold_q, s_tdata};
	assign acc = s_tvalid && s_tready;
	assign s_tready = !busy_s && !dstart && !inflight_q && !out_v_q;
	assign fire = acc && pos_q >= POS_W'(DATA_START) && pos_q[0] != DATA_START[0]
		&& done_q < btot_q;
	assign dstart = 1'b0;

	// start angle: 2^32/360 = 11930464 + 32/45, fraction by reciprocal
	assign frac_p = 29'({start_q, 5'd0}) * 29'd23302;
	assign ang_base = 32'(start_q) * 32'd11930464 + 32'(frac_p[28:20]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
			span_q <= SPAN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START: start_q <= cfg_data;
				REG_SPAN: span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic div_go;
	assign div_go = acc && pos_q == POS_W'(71);
	assign dnum = {span_q, 32'd0};
	assign dden = 25'(word) * 25'd360;
	sptp_div u_div (.clk, .arst_n, .start(div_go), .num(dnum), .den(dden),
		.busy(busy_s), .quo);

	logic [31:0] inc_q;
	logic div_busy_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_busy_d_q <= 1'b0;
		else div_busy_d_q <= busy_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; btot_q <= '0; rstep_q <= '0; ping_q <= '0; dat_q <= '0;
			hold_q <= '0; ang_q <= '0; inc_q <= '0; done_q <= '0;
		end else begin
			if (div_busy_d_q && !busy_s) inc_q <= quo;
			if (acc) begin
				if (pos_q == 70 || pos_q == 85 || pos_q == 118 || pos_q == 120)
					hold_q <= s_tdata;
				else if (pos_q == 71) begin
					btot_q <= word;
					ang_q <= ang_base;
					inc_q <= '0;
					done_q <= '0;
				end else if (pos_q == 86) rstep_q <= word;
				else if (pos_q == 119) ping_q <= word;
				else if (pos_q == 121) dat_q <= word;
				else if (pos_q >= POS_W'(DATA_START)) begin
					if (pos_q[0] == DATA_START[0]) hold_q <= s_tdata;
					else if (fire) begin
						done_q <= done_q + 16'd1;
						ang_q <= ang_q + inc_q;
					end
				end
				if (s_tuser) pos_q <= '0;
				else if (pos_q < POS_MAX) pos_q <= pos_q + 1'b1;
			end
		end
	end

	// fold into +-90 degrees
	logic signed [33:0] z0;
	logic flip;
	always_comb begin
		z0 = $signed({{2{ang_q[31]}}, ang_q});
		flip = 1'b0;
		if (z0 > Q30) begin z0 = z0 - (34'sd1 <<< 31); flip = 1'b1; end
		else if (z0 < -Q30) begin z0 = z0 + (34'sd1 <<< 31); flip = 1'b1; end
	end

	logic flip_q;
	logic [31:0] rr_q;
	logic signed [33:0] cx [NC+1];
	logic signed [33:0] cy [NC+1];
	logic signed [33:0] cz [NC+1];
	logic cv [NC+1];
	always_ff @(posedge clk) begin
		if (fire) begin
			ctl_q <= '{beam: done_q, last: (done_q + 16'd1 == btot_q)};
			flip_q <= flip;
			rr_q <= word * rstep_q;
			cx[0] <= CORDIC_GAIN;
			cy[0] <= '0;
			cz[0] <= z0;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv[0] <= 1'b0;
		else cv[0] <= fire;
	end
	for (genvar g = 0; g < NC; g++) begin : g_cell
		sptp_cell #(.STEP(g)) u_cell (.clk, .arst_n, .vin(cv[g]), .xin(cx[g]),
			.yin(cy[g]), .zin(cz[g]), .vout(cv[g+1]), .xout(cx[g+1]),
			.yout(cy[g+1]), .zout(cz[g+1]));
	end

	function automatic logic signed [33:0] trnd(input logic signed [33:0] v, input logic f);
		logic signed [33:0] w, r;
		w = f ? -v : v;
		r = (w + (34'sd1 <<< (SH - 1))) >>> SH;
		if (r > LIM - 1) r = LIM - 1;
		if (r < -(LIM - 1)) r = -(LIM - 1);
		return r;
	endfunction

	logic signed [33:0] c_s1, s_s1;
	logic [TRIG_BITS-1:0] ac_s1, as_s1;
	logic v_s1, v_s2;
	logic [63:0] mc_s2, ms_s2;
	logic nc_s2, ns_s2;
	assign ac_s1 = TRIG_BITS'(c_s1[33] ? -c_s1 : c_s1);
	assign as_s1 = TRIG_BITS'(s_s1[33] ? -s_s1 : s_s1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin v_s1 <= 1'b0; v_s2 <= 1'b0; end
		else begin v_s1 <= cv[NC]; v_s2 <= v_s1; end
	end
	always_ff @(posedge clk) begin
		c_s1 <= trnd(cx[NC], flip_q);
		s_s1 <= trnd(cy[NC], flip_q);
		nc_s2 <= c_s1[33];
		ns_s2 <= s_s1[33];
		mc_s2 <= 64'(rr_q) * 64'(ac_s1);
		ms_s2 <= 64'(rr_q) * 64'(as_s1);
	end

	logic [63:0] qc, qs;
	logic [32:0] xo, yo;
	assign qc = (mc_s2 + (64'd1 << (TRIG_BITS - 2))) >> (TRIG_BITS - 1);
	assign qs = (ms_s2 + (64'd1 << (TRIG_BITS - 2))) >> (TRIG_BITS - 1);
	assign xo = nc_s2 ? 33'(64'd0 - qc) : qc[32:0];
	assign yo = ns_s2 ? 33'(64'd0 - qs) : qs[32:0];

	logic [16:0] lat;
	assign lat = 17'(ping_q) + 17'(dat_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (fire) inflight_q <= 1'b1;
			else if (v_s2) inflight_q <= 1'b0;
			if (v_s2) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (v_s2) begin
			m_tdata <= {5'd0, lat, ctl_q.beam, yo, xo};
			m_tuser <= ctl_q.last;
		end
	end
	assign m_tvalid = out_v_q;

	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q |-> !s_tready) else $error("byte taken during point");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !out_v_q) else $error("output overrun");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s |-> !fire) else $error("point during divide");
endmodule

// ----- tb/sonar_packet_to_points_tb.sv -----
// testbench for sonar_packet_to_points: byte stream in, predicted points checked at output
`timescale 1ns / 1ps
module sonar_packet_to_points_tb;
	import sptp_pkg::*;

	localparam int TRIG_W = TRIG_BITS_DEF;
	localparam int SETTLE = TRIG_BITS_DEF + 4 + 42 + 40;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [32:0] x;
		logic [32:0] y;
		logic [15:0] beam;
		logic [16:0] lat;
		logic        last;
	} point_t;

	class point_scoreboard;
		point_t     pending[$];
		int         errors;
		logic [8:0] start_deg, span_deg;
		logic [17:0] pos;
		logic [15:0] beams, res, ping_lat, data_lat, done;
		logic [7:0]  hi;
		logic [31:0] ang, ang_step;

		function new();
			errors = 0;
			start_deg = START_RST;
			span_deg = SPAN_RST;
			pos = '0;
			beams = '0; res = '0; ping_lat = '0; data_lat = '0; done = '0;
			hi = '0; ang = '0; ang_step = '0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [8:0] val);
			if (idx == REG_START)
				start_deg = val;
			else
				span_deg = val;
		endfunction

		function longint trig_round(longint v);
			longint r;
			longint lim;
			lim = (longint'(1) <<< (TRIG_W - 1)) - 1;
			r = (v + (longint'(1) <<< (31 - TRIG_W - 1))) >>> (31 - TRIG_W);
			if (r > lim) r = lim;
			if (r < -lim) r = -lim;
			return r;
		endfunction

		function void rotate(logic [31:0] a, output longint c, output longint s);
			longint atan_q[24];
			longint z, xx, yy, dx, dy;
			bit flip;
			atan_q = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
				41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
			z = longint'({32'b0, a});
			xx = 652032874;
			yy = 0;
			flip = 0;
			if (z >= (longint'(1) <<< 31)) z -= longint'(1) <<< 32;
			if (z > 1073741824) begin
				z -= longint'(1) <<< 31;
				flip = 1;
			end else if (z < -1073741824) begin
				z += longint'(1) <<< 31;
				flip = 1;
			end
			for (int i = 0; i < TRIG_W && i < 24; i++) begin
				dx = yy >>> i;
				dy = xx >>> i;
				if (z >= 0) begin
					xx -= dx; yy += dy; z -= atan_q[i];
				end else begin
					xx += dx; yy -= dy; z += atan_q[i];
				end
			end
			if (flip) begin
				xx = -xx;
				yy = -yy;
			end
			c = trig_round(xx);
			s = trig_round(yy);
		endfunction

		function logic [32:0] scale(longint rr, longint t);
			longint mag, q;
			mag = rr * (t < 0 ? -t : t);
			q = (mag + (longint'(1) <<< (TRIG_W - 2))) >>> (TRIG_W - 1);
			if (t < 0) q = -q;
			return q[32:0];
		endfunction

		function void note_byte(logic [7:0] b, logic eop);
			logic [15:0] word;
			longint c, s, rr;
			point_t p;
			word = {hi, b};
			if (pos == 70 || pos == 85 || pos == 118 || pos == 120) begin
				hi = b;
			end else if (pos == 71) begin
				beams = word;
				ang = 32'(({55'b0, start_deg} << 32) / 64'd360);
				ang_step = (word == 0) ? 32'd0 :
					32'(({55'b0, span_deg} << 32) / (64'd360 * word));
				done = '0;
			end else if (pos == 86) begin
				res = word;
			end else if (pos == 119) begin
				ping_lat = word;
			end else if (pos == 121) begin
				data_lat = word;
			end else if (pos >= DATA_START_DEF) begin
				if (((pos - DATA_START_DEF) & 1) == 0) begin
					hi = b;
				end else if (done < beams) begin
					rr = longint'(word) * longint'(res);
					rotate(ang, c, s);
					p.x = scale(rr, c);
					p.y = scale(rr, s);
					p.beam = done;
					p.lat = {1'b0, ping_lat} + {1'b0, data_lat};
					p.last = (17'(done) + 1 == 17'(beams));
					pending.push_back(p);
					done++;
					ang += ang_step;
				end
			end
			if (eop)
				pos = '0;
			else if (pos < POS_MAX)
				pos++;
		endfunction

		function void check_point(logic [103:0] data, logic last);
			point_t got, want;
			got.x = data[32:0];
			got.y = data[65:33];
			got.beam = data[81:66];
			got.lat = data[98:82];
			got.last = last;
			if (pending.size() == 0) begin
				$display("%0t: unexpected point x=%0d y=%0d beam=%0d", $time,
					$signed(got.x), $signed(got.y), got.beam);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.x !== want.x) begin
				$display("%0t: x_mm expected %0d got %0d", $time, $signed(want.x), $signed(got.x));
				errors++;
			end
			if (got.y !== want.y) begin
				$display("%0t: y_mm expected %0d got %0d", $time, $signed(want.y), $signed(got.y));
				errors++;
			end
			if (got.beam !== want.beam) begin
				$display("%0t: beam_index expected %0d got %0d", $time, want.beam, got.beam);
				errors++;
			end
			if (got.lat !== want.lat) begin
				$display("%0t: latency_total expected %0d got %0d", $time, want.lat, got.lat);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_point expected %0b got %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [8:0]   cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic         m_tuser;

	point_scoreboard sb;
	int     idle_mode;
	logic   stall_req;
	logic   stall_taken;
	int     hold_left;
	longint cycles;
	int     beats_sent;

	sonar_packet_to_points u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver side: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			stall_taken <= 1'b0;
		end else if (stall_req && !stall_taken) begin
			stall_taken <= 1'b1;
			hold_left <= 600;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			case (idle_mode)
				2: m_tready <= ($urandom_range(99) >= 85);
				3: m_tready <= ($urandom_range(99) >= 33);
				default: m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_point(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sonar_packet_to_points_tb: done, errors");
			$finish;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic eop);
		bit gap;
		forever begin
			case (idle_mode)
				1: gap = ($urandom_range(99) < 85);
				3: gap = ($urandom_range(99) < 33);
				default: gap = 0;
			endcase
			if (!gap)
				break;
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= eop;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_byte(b, eop);
		beats_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [8:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// len counts all bytes; eop marks the final one; phases rotate every 24 beats
	task automatic send_packet(input logic [15:0] nbeams, input logic [15:0] res,
		input logic [15:0] ping, input logic [15:0] dlat, input int len,
		input bit hold_off);
		logic [7:0] b;
		logic [15:0] w;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			case (i)
				70: b = nbeams[15:8];
				71: b = nbeams[7:0];
				85: b = res[15:8];
				86: b = res[7:0];
				118: b = ping[15:8];
				119: b = ping[7:0];
				120: b = dlat[15:8];
				121: b = dlat[7:0];
				default: ;
			endcase
			if (i >= DATA_START_DEF && i < 262400) begin
				if (((i - DATA_START_DEF) & 1) == 0) begin
					w = pick_word();
					b = w[15:8];
				end else begin
					b = w[7:0];
				end
			end
			if (hold_off && i == DATA_START_DEF + 4)
				stall_req <= 1'b1;
			idle_mode = (beats_sent / 24) % 4;
			send_beat(b, i == len - 1);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		stall_req = 1'b0;
		idle_mode = 0;
		cycles = 0;
		beats_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset fan, extremes of fields and an extra word, zero beams, early end
		send_packet(16'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, DATA_START_DEF + 10, 1'b0);
		write_reg(REG_START, 9'd0);
		write_reg(REG_SPAN, 9'd360);
		send_packet(16'd0, 16'd100, 16'd1, 16'd2, 80, 1'b0);
		send_packet(16'd2, 16'd3, 16'd3, 16'd3, 40, 1'b0);

		// out of range fan, packet ends before its last beam, long receiver hold-off
		write_reg(REG_START, 9'd511);
		write_reg(REG_SPAN, 9'd511);
		send_packet(16'd60, 16'd1000, 16'h8000, 16'h7FFF, DATA_START_DEF + 104, 1'b1);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("sonar_packet_to_points_tb: done, clean");
		else
			$display("sonar_packet_to_points_tb: done, errors");
		$finish;
	end
endmodule
